// ===== rtl/ordered_list_engine_macros.svh =====
// assertion macros shared by the ordered list engine rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, off while in reset
`define OLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define OLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ole_pkg.sv =====
// types and codes for the ordered list engine
// no dependencies; used by every rtl module of the block
`default_nettype none

package ole_pkg;

  // widest list the cell command can address, and its index width
  localparam int MAX_CAPACITY = 64;
  localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_INS_KEY   = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_POS   = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [4:0]         position;
    logic signed [31:0] key;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_out;
    logic [4:0]         entry_index;
    logic [4:0]         entry_count;
    logic               last;
  } out_item_t;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_PLACE = 2'd2,
    S_READ  = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ole_cell.sv =====
// one list cell: holds one word and moves it along the chain
// depends on ole_pkg (cell command struct)
`default_nettype none

module ole_cell import ole_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire cell_cmd_t             cmd,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic [DATA_WIDTH-1:0] load_data,
  input  wire logic [DATA_WIDTH-1:0] key,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       match,
  output logic      [DATA_WIDTH-1:0] tap
);

  localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      CMD_INS: begin
        if (IDX == cmd.slot) begin
          data_nxt = load_data;
        end else if (IDX > cmd.slot && IDX <= cmd.count) begin
          data_nxt = left_data;
        end
      end
      CMD_DEL: begin
        if (IDX >= cmd.slot && IDX_NEXT < cmd.count) begin
          data_nxt = right_data;
        end
      end
      CMD_ROT: begin
        // tail cell takes the old head word
        if (IDX_NEXT < cmd.count) begin
          data_nxt = right_data;
        end else if (IDX_NEXT == cmd.count) begin
          data_nxt = load_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);
  assign tap   = (cmd.kind == CMD_DEL && IDX == cmd.slot) ? data_r : '0;

endmodule

`default_nettype wire

// ===== rtl/ole_out_queue.sv =====
// two-entry result queue between the list engine and the result channel
// depends on ole_pkg (result item struct)
`default_nettype none

module ole_out_queue import ole_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  out_item_t  entries_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill_r != 2'd0);
  assign room      = (fill_r != 2'd2);
  assign out_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// ordered list engine top level: request decode, cell chain, result queue
// depends on ole_pkg, ole_cell, ole_out_queue and ordered_list_engine_macros.svh
//
//   channel   ports                            payload
//   -------   ------------------------------   ----------------------------------
//   request   in_valid / in_ready / in_data    op, value, position, key
//   result    out_valid / out_ready / out_data status, data_out, entry_index,
//                                              entry_count, last
//
// edits at the front, back or a position finish in the transfer cycle
// insert after key goes in steps: compare in every cell, register hits, pick first and shift
// read out gives one entry per cycle while the result queue has room, as the chain rotates once round
// rst_n (synchronous) empties the list; cell words are not cleared
// a full result queue stalls read out and key placement and blocks new requests
`default_nettype none

module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

`include "ordered_list_engine_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  // control state
  state_t          state_r;
  state_t          state_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   rd_idx_r;
  logic [CW-1:0]   rd_idx_nxt;

  // request words held across the key search
  logic [DATA_WIDTH-1:0] value_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [CAPACITY-1:0]   match_r;

  // cell chain wiring
  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap   [CAPACITY];
  logic [DATA_WIDTH-1:0] left_bus   [CAPACITY];
  logic [DATA_WIDTH-1:0] right_bus  [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] load_word;
  logic [DATA_WIDTH-1:0] tap_or;

  // request decode helpers
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  in_is_ins;
  logic [DATA_WIDTH-1:0] in_word;
  logic [DATA_WIDTH-1:0] in_key;
  logic [CNT_W-1:0]      n_ext;
  logic [CNT_W-1:0]      pos_ext;
  logic [CAPACITY-1:0]   valid_mask;
  logic                  hit;
  logic [CNT_W-1:0]      hit_slot;
  logic [CW-1:0]         rd_next;
  logic                  rd_last;

  // result queue side
  logic      push;
  out_item_t push_item;
  logic      room;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && room;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign in_is_ins = (in_data.op == OP_INS_FRONT) || (in_data.op == OP_INS_BACK) ||
                     (in_data.op == OP_INS_POS) || (in_data.op == OP_INS_KEY);
  // words live in the low DATA_WIDTH bits
  assign in_word   = DATA_WIDTH'($unsigned(in_data.value));
  assign in_key    = DATA_WIDTH'($unsigned(in_data.key));
  assign n_ext     = CNT_W'(cnt_r);
  assign pos_ext   = CNT_W'(in_data.position);
  assign rd_next   = rd_idx_r + CW'(1);
  assign rd_last   = (rd_next == cnt_r);

  // the chain: neighbors pass words left or right, ends see zero
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_bus[g] = '0;
    end else begin : g_left
      assign left_bus[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_bus[g] = '0;
    end else begin : g_right
      assign right_bus[g] = cell_data[g+1];
    end

    ole_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_bus[g]),
      .right_data (right_bus[g]),
      .load_data  (load_word),
      .key        (key_r),
      .data       (cell_data[g]),
      .match      (cell_match[g]),
      .tap        (cell_tap[g])
    );
  end

  // removed word: only the deleted cell drives its tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // cells at or past the count hold stale words and must not match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_mask[i] = (CW'(i) < cnt_r);
    end
  end

  // first registered hit; new word goes right after it
  always_comb begin
    hit      = |match_r;
    hit_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_slot = CNT_W'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_INS_KEY && !full && !empty) begin
            state_nxt = S_MATCH;
          end else if (in_data.op == OP_READ && !empty) begin
            state_nxt = S_READ;
          end
        end
      end
      S_MATCH: state_nxt = S_PLACE;
      S_PLACE: begin
        if (room) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (room && rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain command, count update and result item
  always_comb begin
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    cmd        = '{kind: CMD_HOLD, slot: '0, count: n_ext};
    load_word  = in_word;
    push       = 1'b0;
    push_item  = '{status: ST_OK, data_out: '0, entry_index: '0, entry_count: '0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_is_ins && full) begin
            push             = 1'b1;
            push_item.status = ST_FULL;
          end else begin
            case (in_data.op)
              OP_INS_FRONT: begin
                push     = 1'b1;
                cmd.kind = CMD_INS;
                cmd.slot = '0;
                cnt_nxt  = cnt_r + CW'(1);
              end
              OP_INS_BACK: begin
                push     = 1'b1;
                cmd.kind = CMD_INS;
                cmd.slot = n_ext;
                cnt_nxt  = cnt_r + CW'(1);
              end
              OP_INS_POS: begin
                push = 1'b1;
                if (empty || pos_ext <= CNT_W'(1)) begin
                  cmd.kind = CMD_INS;
                  cmd.slot = '0;
                  cnt_nxt  = cnt_r + CW'(1);
                end else if (pos_ext > n_ext + CNT_W'(1)) begin
                  push_item.status = ST_BADPOS;
                end else begin
                  cmd.kind = CMD_INS;
                  cmd.slot = pos_ext - CNT_W'(1);
                  cnt_nxt  = cnt_r + CW'(1);
                end
              end
              OP_INS_KEY: begin
                // empty list: word becomes the only entry; else search first
                if (empty) begin
                  push     = 1'b1;
                  cmd.kind = CMD_INS;
                  cmd.slot = '0;
                  cnt_nxt  = cnt_r + CW'(1);
                end
              end
              OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                push = 1'b1;
                if (empty) begin
                  push_item.status = ST_EMPTY;
                end else if (in_data.op == OP_DEL_POS &&
                             (pos_ext == '0 || pos_ext > n_ext)) begin
                  push_item.status = ST_BADPOS;
                end else begin
                  cmd.kind = CMD_DEL;
                  if (in_data.op == OP_DEL_FRONT) begin
                    cmd.slot = '0;
                  end else if (in_data.op == OP_DEL_BACK) begin
                    cmd.slot = n_ext - CNT_W'(1);
                  end else begin
                    cmd.slot = pos_ext - CNT_W'(1);
                  end
                  push_item.data_out = 32'(tap_or);
                  cnt_nxt            = cnt_r - CW'(1);
                end
              end
              OP_READ: begin
                if (empty) begin
                  push             = 1'b1;
                  push_item.status = ST_EMPTY;
                end else begin
                  rd_idx_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PLACE: begin
        if (room) begin
          push = 1'b1;
          if (hit) begin
            cmd.kind  = CMD_INS;
            cmd.slot  = hit_slot;
            load_word = value_r;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            push_item.status = ST_NOTFOUND;
          end
        end
      end
      S_READ: begin
        // head word goes out, chain rotates left, head wraps to the tail
        if (room) begin
          push                  = 1'b1;
          push_item.data_out    = 32'(cell_data[0]);
          push_item.entry_index = 5'(rd_next);
          push_item.last        = rd_last;
          cmd.kind              = CMD_ROT;
          load_word             = cell_data[0];
          rd_idx_nxt            = rd_next;
        end
      end
      default: ;
    endcase
    push_item.entry_count = 5'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_word;
      key_r   <= in_key;
    end
    if (state_r == S_MATCH) begin
      match_r <= cell_match & valid_mask;
    end
  end

  ole_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `OLE_ASSERT_NXT(a_full_keeps_count, accept && in_is_ins && full, $stable(cnt_r), "insert into full list changed the count")
  `OLE_ASSERT_NXT(a_read_keeps_count, state_r == S_READ, $stable(cnt_r), "count moved during read out")
  `OLE_ASSERT_NXT(a_read_ends_idle, state_r == S_READ && push && rd_last, state_r == S_IDLE, "read out did not finish after last entry")
  `OLE_ASSERT_IMP(a_push_has_room, push, room, "result pushed into a full queue")

endmodule

`default_nettype wire
